[rtl/cmnm_pkg.sv]
// Shared types, constants and chord interval table of the chord mode note mapper.
`timescale 1ns / 1ps
`default_nettype none

package cmnm_pkg;

    localparam int CHORD_NOTES   = 4;
    localparam int QUALITY_ZONE  = 12;
    localparam int NUM_SLOTS     = 10;
    localparam int SLOT_W        = 4;
    localparam int CMD_DEPTH     = 2;
    localparam int CMD_PTR_W     = 1;
    localparam int APB_AW        = 3;

    localparam logic [SLOT_W-1:0] SLOT_ON_LO    = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_BASS_OFF = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_BASS_ON  = 4'd9;

    localparam logic [1:0] CMD_PASS     = 2'd0;
    localparam logic [1:0] CMD_ROOT_ON  = 2'd1;
    localparam logic [1:0] CMD_ROOT_OFF = 2'd2;

    localparam logic REG_ENABLED = 1'b0;
    localparam logic REG_SPLIT   = 1'b1;

    localparam logic [6:0] SPLIT_MIN   = 7'd36;
    localparam logic [6:0] SPLIT_MAX   = 7'd84;
    localparam logic [6:0] SPLIT_RESET = 7'd60;

    typedef struct packed {
        logic       kind;
        logic [6:0] note;
        logic [6:0] velocity;
    } t_item;

    typedef struct packed {
        logic       note_on;
        logic [7:0] note_res;
        logic [6:0] velocity_res;
        logic       direct_layer;
        logic       last;
    } t_res;

    typedef struct packed {
        logic       enabled;
        logic [6:0] split_note;
    } t_cfg;

    typedef struct packed {
        logic [1:0] op;
        logic       kind;
        logic [6:0] note;
        logic [6:0] vel;
        logic [3:0] quality;
    } t_cmd;

    typedef struct packed {
        logic [CHORD_NOTES-1:0]      vld;
        logic [CHORD_NOTES-1:0][3:0] ivl;
    } t_chord;

    // interval sets, tone 0 in the low nibble
    function automatic t_chord chord_row(input logic [3:0] q);
        t_chord r;
        r.vld = 4'b1111;
        case (q)
            4'd0: begin r.ivl = {4'd0, 4'd7, 4'd4, 4'd0};  r.vld = 4'b0111; end
            4'd1: begin r.ivl = {4'd0, 4'd7, 4'd3, 4'd0};  r.vld = 4'b0111; end
            4'd2: begin r.ivl = {4'd10, 4'd7, 4'd4, 4'd0}; end
            4'd3: begin r.ivl = {4'd10, 4'd7, 4'd3, 4'd0}; end
            4'd4: begin r.ivl = {4'd11, 4'd7, 4'd4, 4'd0}; end
            4'd5: begin r.ivl = {4'd9, 4'd7, 4'd4, 4'd0};  end
            4'd6: begin r.ivl = {4'd10, 4'd6, 4'd3, 4'd0}; end
            4'd7: begin r.ivl = {4'd9, 4'd6, 4'd3, 4'd0};  end
            4'd8: begin r.ivl = {4'd0, 4'd8, 4'd4, 4'd0};  r.vld = 4'b0111; end
            4'd9: begin r.ivl = {4'd0, 4'd7, 4'd2, 4'd0};  r.vld = 4'b0111; end
            4'd10: begin r.ivl = {4'd0, 4'd7, 4'd5, 4'd0}; r.vld = 4'b0111; end
            default: begin r.ivl = {4'd9, 4'd7, 4'd3, 4'd0}; end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/cmnm_front.sv]
// Front end: accepts note events, tracks quality and held root, issues commands.
`timescale 1ns / 1ps
`default_nettype none

module cmnm_front
    import cmnm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_cmd_push,
    output t_cmd       o_cmd,
    input  wire logic  i_cmd_full
);

    logic       r_held_vld;
    logic [6:0] r_held_note;
    logic [3:0] r_quality;

    logic       acc;
    logic [6:0] zone_lo;
    logic       in_root;
    logic       in_qual;
    logic       held_match;

    assign o_full     = i_cmd_full;
    assign acc        = i_push && !i_cmd_full;
    assign zone_lo    = i_cfg.split_note - 7'(QUALITY_ZONE);
    assign in_root    = i_cfg.enabled && (i_item.note >= i_cfg.split_note);
    assign in_qual    = i_cfg.enabled && !in_root && (i_item.note >= zone_lo);
    assign held_match = r_held_vld && (i_item.note == r_held_note);

    always_comb begin
        o_cmd.op      = in_root ? (i_item.kind ? CMD_ROOT_ON : CMD_ROOT_OFF) : CMD_PASS;
        o_cmd.kind    = i_item.kind;
        o_cmd.note    = i_item.note;
        o_cmd.vel     = i_item.velocity;
        o_cmd.quality = r_quality;
        o_cmd_push    = acc && ((!in_root && !in_qual) ||
                                (in_root && (i_item.kind || held_match)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vld <= 1'b0;
            r_quality  <= 4'd0;
        end else if (acc) begin
            if (in_root && i_item.kind) begin
                r_held_vld <= 1'b1;
            end else if (in_root && held_match) begin
                r_held_vld <= 1'b0;
            end
            if (in_qual && i_item.kind) begin
                r_quality <= 4'(i_item.note - zone_lo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && in_root && i_item.kind) begin
            r_held_note <= i_item.note;
        end
    end

endmodule

`default_nettype wire

[rtl/cmnm_cmd_fifo.sv]
// Two-entry command queue between front end and sequencer.
`timescale 1ns / 1ps
`default_nettype none

module cmnm_cmd_fifo
    import cmnm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output logic      o_empty
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wptr;
    logic [CMD_PTR_W-1:0] r_rptr;
    logic [CMD_PTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + CMD_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + CMD_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (CMD_PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (CMD_PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/cmnm_back.sv]
// Sequencer: diffs the new chord against the sounding one and emits note words.
`timescale 1ns / 1ps
`default_nettype none

module cmnm_back
    import cmnm_pkg::*;
#(
    parameter int MAX_RESULTS = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_empty,
    output logic      o_cmd_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_res      o_res
);

    localparam int CW = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    // sounding chord and bass
    logic [7:0]           r_snd [CHORD_NOTES];
    logic [2:0]           r_snd_cnt;
    logic                 r_bass_vld;
    logic [6:0]           r_bass_note;
    // pending words: slots 0-3 chord offs, 4-7 chord ons, 8 bass off, 9 bass on
    logic [NUM_SLOTS-1:0] r_mask;
    logic [7:0]           r_note [NUM_SLOTS];
    logic [6:0]           r_vel;
    logic [CW-1:0]        r_cnt;
    logic                 r_out_vld;
    t_res                 r_out;

    t_chord                 row;
    logic [7:0]             tone [CHORD_NOTES];
    logic [CHORD_NOTES-1:0] tvld;
    logic [CHORD_NOTES-1:0] svld;
    logic [CHORD_NOTES-1:0] off_bits;
    logic [CHORD_NOTES-1:0] on_bits;
    logic                   root_vld;
    logic                   bass_diff;
    logic [NUM_SLOTS-1:0]   n_mask;
    logic [SLOT_W-1:0]      sel;
    logic [NUM_SLOTS-1:0]   remaining;
    logic                   emit;
    t_res                   n_out;

    assign o_cmd_pop = !i_cmd_empty && (r_mask == '0);
    assign o_empty   = !r_out_vld;
    assign o_res     = r_out;
    assign emit      = (r_mask != '0) && (!r_out_vld || i_pop);

    always_comb begin
        row      = chord_row(i_cmd.quality);
        root_vld = (i_cmd.op == CMD_ROOT_ON);
        for (int j = 0; j < CHORD_NOTES; j++) begin
            tone[j] = {1'b0, i_cmd.note} + {4'b0000, row.ivl[j]};
            tvld[j] = root_vld && row.vld[j];
        end
        for (int i = 0; i < CHORD_NOTES; i++) begin
            svld[i] = (3'(i) < r_snd_cnt);
        end
        for (int i = 0; i < CHORD_NOTES; i++) begin
            off_bits[i] = svld[i];
            for (int j = 0; j < CHORD_NOTES; j++) begin
                if (tvld[j] && (tone[j] == r_snd[i])) begin
                    off_bits[i] = 1'b0;
                end
            end
        end
        for (int j = 0; j < CHORD_NOTES; j++) begin
            on_bits[j] = tvld[j];
            for (int i = 0; i < CHORD_NOTES; i++) begin
                if (svld[i] && (r_snd[i] == tone[j])) begin
                    on_bits[j] = 1'b0;
                end
            end
        end
        bass_diff = (root_vld != r_bass_vld) || (root_vld && (r_bass_note != i_cmd.note));
        if (i_cmd.op == CMD_PASS) begin
            n_mask = i_cmd.kind ? (NUM_SLOTS'(1) << SLOT_BASS_ON)
                                : (NUM_SLOTS'(1) << SLOT_BASS_OFF);
        end else begin
            n_mask = {bass_diff && root_vld, bass_diff && r_bass_vld, on_bits, off_bits};
        end
    end

    always_comb begin
        sel = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = SLOT_W'(k);
            end
        end
        remaining          = r_mask & ~(NUM_SLOTS'(1) << sel);
        n_out.note_on      = ((sel >= SLOT_ON_LO) && (sel < SLOT_BASS_OFF)) ||
                             (sel == SLOT_BASS_ON);
        n_out.note_res     = r_note[sel];
        n_out.velocity_res = n_out.note_on ? r_vel : 7'd0;
        n_out.direct_layer = (sel >= SLOT_BASS_OFF);
        n_out.last         = (remaining == '0) || (r_cnt == CW'(MAX_RESULTS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snd_cnt  <= 3'd0;
            r_bass_vld <= 1'b0;
            r_mask     <= '0;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_mask <= n_mask;
                r_cnt  <= '0;
                if (i_cmd.op != CMD_PASS) begin
                    r_snd_cnt  <= 3'($countones(tvld));
                    r_bass_vld <= root_vld;
                end
            end else if (emit) begin
                r_mask <= n_out.last ? '0 : remaining;
                r_cnt  <= r_cnt + CW'(1);
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_vel <= i_cmd.vel;
            for (int i = 0; i < CHORD_NOTES; i++) begin
                r_note[i] <= r_snd[i];
                r_note[CHORD_NOTES + i] <= tone[i];
            end
            r_note[SLOT_BASS_OFF] <= (i_cmd.op == CMD_PASS) ? {1'b0, i_cmd.note}
                                                            : {1'b0, r_bass_note};
            r_note[SLOT_BASS_ON]  <= {1'b0, i_cmd.note};
            if (i_cmd.op != CMD_PASS) begin
                for (int i = 0; i < CHORD_NOTES; i++) begin
                    r_snd[i] <= tone[i];
                end
                r_bass_note <= i_cmd.note;
            end
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    a_snd_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snd_cnt <= 3'(CHORD_NOTES))
        else $error("sounding count out of range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && n_out.last |=> (r_mask == '0))
        else $error("words pending after last word");

    a_off_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.note_on |-> (r_out.velocity_res == 7'd0))
        else $error("note-off word with nonzero velocity");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !o_cmd_pop)
        else $error("command taken while words pending");

endmodule

`default_nettype wire

[rtl/chord_mode_note_mapper_unit.sv]
// Top level of the chord mode note mapper: config registers and queue channels.
// Usage:
//   Input channel: drive i_item and raise push; the word is taken at a clock edge
//   with push high and full low. Result channel: while empty is low, o_res holds
//   the oldest result word; raise pop to take it.
//   Each input word yields zero to MAX_RESULTS result words; the final word of a
//   group has last set. Quality keys and stale root releases yield none.
//   Flow: a command waits in the two-entry queue until the sequencer has no words
//   pending, and the chord diff is done as it is taken; the sequencer then emits
//   one word per cycle while the output register is empty or being popped. The
//   path to o_res runs through the queue, the sequencer's pending mask and the
//   output register.
//   Config: APB writes at byte address 0 (enabled) and 4 (split note, clamped
//   to 36..84); write only while the block is idle.
//   Reset (i_rst_n low, synchronous): chord mode enabled, split 60, major
//   quality, nothing held or sounding, queue and output empty.
//   When the receiver stalls, the output register holds its word, the sequencer
//   waits, and the queue keeps taking inputs until full.
`timescale 1ns / 1ps
`default_nettype none

module chord_mode_note_mapper_unit
    import cmnm_pkg::*;
#(
    parameter int MAX_RESULTS = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    input  wire t_item             i_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output t_res                   o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic       r_enabled;
    logic [6:0] r_split;
    logic [6:0] n_split;
    logic       cfg_wr;
    t_cfg       cfg;

    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_full;
    logic cmd_pop;
    t_cmd cmd_out;
    logic cmd_empty;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign cfg         = '{enabled: r_enabled, split_note: r_split};

    always_comb begin
        if (pwdata[6:0] < SPLIT_MIN) begin
            n_split = SPLIT_MIN;
        end else if (pwdata[6:0] > SPLIT_MAX) begin
            n_split = SPLIT_MAX;
        end else begin
            n_split = pwdata[6:0];
        end
        case (paddr[2])
            REG_ENABLED: prdata = {31'd0, r_enabled};
            REG_SPLIT:   prdata = {25'd0, r_split};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
            r_split   <= SPLIT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ENABLED: r_enabled <= pwdata[0];
                REG_SPLIT:   r_split   <= n_split;
                default:     r_enabled <= r_enabled;
            endcase
        end
    end

    cmnm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    cmnm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    cmnm_back #(
        .MAX_RESULTS (MAX_RESULTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
